/* rtl/slgt_pkg.sv */
// ----------------------------------------------------------------------------
// slgt_pkg
// Shared types, constants and the arctangent table of the segment look-ahead
// goal tracker.
// ----------------------------------------------------------------------------
package slgt_pkg;

   localparam int MAX_PATH_POINTS = 1024;
   localparam int ANGLE_BITS      = 16;
   localparam int IDX_W           = 10;
   localparam int CNT_W           = 11;

   // item kinds
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_POSE = 1'b1;

   // register indexes
   localparam logic CSR_STEP_INTERVAL = 1'b0;
   localparam logic CSR_LOOKAHEAD     = 1'b1;

   localparam logic [30:0] STEP_INTERVAL_RST = 31'd65536;
   localparam logic [30:0] LOOKAHEAD_RST     = 31'd327680;

   typedef struct packed {
      logic               op;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic        [15:0] pose_heading;
   } req_type;

   typedef struct packed {
      logic signed [31:0] goal_x;
      logic signed [31:0] goal_y;
      logic        [15:0] goal_heading;
      logic  [IDX_W-1:0]  goal_position;
      logic               end_of_path;
   } rsp_type;

   // path record kept in the context memory
   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [32:0] step_dx;
      logic signed [32:0] step_dy;
      logic        [15:0] heading;
      logic  [CNT_W-1:0]  count;
      logic  [IDX_W-1:0]  index;
   } ctx_type;

   // arctangent of 2^-i in 2^32 units per turn
   function automatic logic [31:0] atan_tab(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

/* rtl/segment_lookahead_goal_tracker.sv */
// ----------------------------------------------------------------------------
// segment_lookahead_goal_tracker
// Turns a straight segment into evenly spaced path points and hands out the
// first point at least the look-ahead distance away from a position.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: op 0 loads a segment (start, target, heading),
//   op 1 is a pose update. Each item gives exactly one result on rsp_*.
//   csr_we writes step_interval (index 0) or lookahead_distance (index 1);
//   write only while no item is in flight.
//   The path record (origin, step, heading, count, index) lives in a
//   one-entry context memory with a registered read; an item reads it, works
//   on it, and writes it back when its result is loaded into the output
//   register. One item is in work at a time; req_ready is high only idle.
//   Pose item: a walk with one add, one pair of squares and one compare per
//   point.
//   Segment item: square root and CORDIC (normalize, then 32 rotations)
//   run side by side, then the shared divider runs three passes (step x,
//   step y, point count), then the walk as above.
//   A short or zero-length segment skips the divider.
//   The output register holds a result until rsp_ready; the block waits
//   with the next result while it stalls. Reset returns the registers to
//   their defaults and the path to one point at the origin.
// ----------------------------------------------------------------------------
module segment_lookahead_goal_tracker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  slgt_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output slgt_pkg::rsp_type       rsp_data,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [30:0]             csr_wdata
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_READ   = 5'd1;
   localparam logic [4:0] ST_DELTA  = 5'd2;
   localparam logic [4:0] ST_SQUARE = 5'd3;
   localparam logic [4:0] ST_SUM    = 5'd4;
   localparam logic [4:0] ST_ROOT   = 5'd5;
   localparam logic [4:0] ST_MULL   = 5'd6;
   localparam logic [4:0] ST_DIVX   = 5'd7;
   localparam logic [4:0] ST_DIVY   = 5'd8;
   localparam logic [4:0] ST_DIVC   = 5'd9;
   localparam logic [4:0] ST_WMUL   = 5'd10;
   localparam logic [4:0] ST_WADD   = 5'd11;
   localparam logic [4:0] ST_WPT    = 5'd12;
   localparam logic [4:0] ST_WDIF   = 5'd13;
   localparam logic [4:0] ST_WSQ    = 5'd14;
   localparam logic [4:0] ST_WCMP   = 5'd15;
   localparam logic [4:0] ST_OUT    = 5'd16;

   localparam int CW = slgt_pkg::CNT_W;
   localparam int IW = slgt_pkg::IDX_W;
   localparam logic [32:0] MAX_CNT33 = 33'(slgt_pkg::MAX_PATH_POINTS);

   // configuration
   logic [30:0] step_interval_ff;
   logic [30:0] lookahead_ff;
   logic [30:0] l_eff;

   // control
   logic [4:0]  state_ff;
   logic [4:0]  state_in;
   logic        launched_ff;
   logic        sq_done_ff;
   logic        cr_done_ff;

   // context memory
   slgt_pkg::ctx_type ctx_mem [0:0];
   slgt_pkg::ctx_type ctx_rd_ff;
   slgt_pkg::ctx_type ctx_wr;
   logic              ctx_valid_ff;
   logic              ctx_we;

   // item and working registers
   slgt_pkg::req_type  req_ff;
   logic signed [31:0] origin_x_ff;
   logic signed [31:0] origin_y_ff;
   logic signed [32:0] step_x_ff;
   logic signed [32:0] step_y_ff;
   logic [15:0]        heading_ff;
   logic [CW-1:0]      count_ff;
   logic [IW-1:0]      idx_ff;

   logic signed [32:0] dx_ff;
   logic signed [32:0] dy_ff;
   logic [31:0]        ax_ff;
   logic [31:0]        ay_ff;
   logic               far_ff;
   logic [63:0]        sqx_ff;
   logic [63:0]        sqy_ff;
   logic [64:0]        sum_ff;
   logic               zero_ff;
   logic [32:0]        d_ff;
   logic [62:0]        prodx_ff;
   logic [62:0]        prody_ff;
   logic [61:0]        la_sq_ff;
   logic signed [44:0] nprod_x_ff;
   logic signed [44:0] nprod_y_ff;
   logic signed [44:0] acc_x_ff;
   logic signed [44:0] acc_y_ff;
   logic signed [31:0] gx_ff;
   logic signed [31:0] gy_ff;

   slgt_pkg::rsp_type  rsp_ff;
   logic               rsp_valid_ff;

   // shared units
   logic               sq_start;
   logic               sq_done;
   logic [32:0]        sq_root;
   logic               cr_done;
   logic [15:0]        cr_angle;
   logic               div_start;
   logic               div_done;
   logic [65:0]        div_num;
   logic [32:0]        div_den;
   logic [32:0]        div_quo;

   // combinational helpers
   logic signed [32:0] dx_w;
   logic signed [32:0] dy_w;
   logic [32:0]        adx_w;
   logic [32:0]        ady_w;
   logic [CW-1:0]      n_w;
   logic signed [32:0] ex_w;
   logic signed [32:0] ey_w;
   logic [32:0]        mx_w;
   logic [32:0]        my_w;
   logic [63:0]        dist_sq;
   logic               close;
   logic               more;
   logic [32:0]        qstep;
   logic [32:0]        cnt33;
   logic               out_take;
   logic               req_fire;

   function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
      logic signed [31:0] r;
      if (v > 45'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -45'sd2147483648) begin
         r = -32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   assign l_eff     = (step_interval_ff == 31'd0) ? 31'd1 : step_interval_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_take  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_interval_ff <= slgt_pkg::STEP_INTERVAL_RST;
         lookahead_ff     <= slgt_pkg::LOOKAHEAD_RST;
      end else if (csr_we) begin
         case (csr_index)
            slgt_pkg::CSR_STEP_INTERVAL: step_interval_ff <= csr_wdata;
            slgt_pkg::CSR_LOOKAHEAD:     lookahead_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // context memory: registered read at accept, write back with the result
   assign ctx_we = out_take;
   always_comb begin
      ctx_wr.origin_x = origin_x_ff;
      ctx_wr.origin_y = origin_y_ff;
      ctx_wr.step_dx  = step_x_ff;
      ctx_wr.step_dy  = step_y_ff;
      ctx_wr.heading  = heading_ff;
      ctx_wr.count    = count_ff;
      ctx_wr.index    = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (ctx_we) begin
         ctx_mem[0] <= ctx_wr;
      end
      if (req_fire) begin
         ctx_rd_ff <= ctx_mem[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_valid_ff <= 1'b0;
      end else if (ctx_we) begin
         ctx_valid_ff <= 1'b1;
      end
   end

   // segment deltas
   assign dx_w  = {req_ff.target_x[31], req_ff.target_x} - {req_ff.pos_x[31], req_ff.pos_x};
   assign dy_w  = {req_ff.target_y[31], req_ff.target_y} - {req_ff.pos_y[31], req_ff.pos_y};
   assign adx_w = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
   assign ady_w = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);

   // walk helpers
   assign n_w     = {1'b0, idx_ff} + CW'(1);
   assign ex_w    = {gx_ff[31], gx_ff} - {req_ff.pos_x[31], req_ff.pos_x};
   assign ey_w    = {gy_ff[31], gy_ff} - {req_ff.pos_y[31], req_ff.pos_y};
   assign mx_w    = ex_w[32] ? 33'(-ex_w) : 33'(ex_w);
   assign my_w    = ey_w[32] ? 33'(-ey_w) : 33'(ey_w);
   assign dist_sq = sqx_ff + sqy_ff;
   assign close   = !far_ff && (dist_sq < {2'b00, la_sq_ff});
   assign more    = (n_w < count_ff);

   // divider operands by pass
   always_comb begin
      case (state_ff)
         ST_DIVX: begin
            div_num = 66'(prodx_ff) + 66'(d_ff[32:1]);
            div_den = d_ff;
         end
         ST_DIVY: begin
            div_num = 66'(prody_ff) + 66'(d_ff[32:1]);
            div_den = d_ff;
         end
         default: begin
            div_num = 66'(d_ff) + 66'(l_eff) - 66'd1;
            div_den = {2'b00, l_eff};
         end
      endcase
   end

   assign div_start = !launched_ff &&
                      ((state_ff == ST_DIVX) || (state_ff == ST_DIVY) ||
                       (state_ff == ST_DIVC));
   assign sq_start  = !launched_ff && (state_ff == ST_ROOT) && !zero_ff;
   assign qstep     = {1'b0, div_quo[31:0]};
   assign cnt33     = (div_quo > 33'd1) ? div_quo - 33'd1 : 33'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_READ;
         ST_READ:   state_in = (req_ff.op == slgt_pkg::OP_LOAD) ? ST_DELTA : ST_WMUL;
         ST_DELTA:  state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_ROOT;
         ST_ROOT: begin
            if (zero_ff) begin
               state_in = ST_WMUL;
            end else if (launched_ff && (sq_done_ff || sq_done) &&
                         (cr_done_ff || cr_done)) begin
               state_in = ST_MULL;
            end
         end
         ST_MULL: state_in = (d_ff < {2'b00, l_eff}) ? ST_WMUL : ST_DIVX;
         ST_DIVX: if (div_done) state_in = ST_DIVY;
         ST_DIVY: if (div_done) state_in = ST_DIVC;
         ST_DIVC: if (div_done) state_in = ST_WMUL;
         ST_WMUL: state_in = ST_WADD;
         ST_WADD: state_in = ST_WPT;
         ST_WPT:  state_in = ST_WDIF;
         ST_WDIF: state_in = ST_WSQ;
         ST_WSQ:  state_in = ST_WCMP;
         ST_WCMP: state_in = (more && close) ? ST_WPT : ST_OUT;
         ST_OUT:  if (out_take) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // advance the control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         launched_ff <= 1'b0;
         sq_done_ff  <= 1'b0;
         cr_done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_in != state_ff) begin
            launched_ff <= 1'b0;
            sq_done_ff  <= 1'b0;
            cr_done_ff  <= 1'b0;
         end else begin
            if (sq_start || div_start) launched_ff <= 1'b1;
            if (sq_done) sq_done_ff <= 1'b1;
            if (cr_done) cr_done_ff <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) req_ff <= req_data;
         end
         ST_READ: begin
            // take the stored path, or the reset path before any write
            if (ctx_valid_ff) begin
               origin_x_ff <= ctx_rd_ff.origin_x;
               origin_y_ff <= ctx_rd_ff.origin_y;
               step_x_ff   <= ctx_rd_ff.step_dx;
               step_y_ff   <= ctx_rd_ff.step_dy;
               heading_ff  <= ctx_rd_ff.heading;
               count_ff    <= ctx_rd_ff.count;
               idx_ff      <= ctx_rd_ff.index;
            end else begin
               origin_x_ff <= '0;
               origin_y_ff <= '0;
               step_x_ff   <= '0;
               step_y_ff   <= '0;
               heading_ff  <= '0;
               count_ff    <= CW'(1);
               idx_ff      <= '0;
            end
         end
         ST_DELTA: begin
            origin_x_ff <= req_ff.pos_x;
            origin_y_ff <= req_ff.pos_y;
            idx_ff      <= '0;
            dx_ff       <= dx_w;
            dy_ff       <= dy_w;
            ax_ff       <= adx_w[31:0];
            ay_ff       <= ady_w[31:0];
         end
         ST_SQUARE: begin
            sqx_ff <= ax_ff * ax_ff;
            sqy_ff <= ay_ff * ay_ff;
         end
         ST_SUM: begin
            sum_ff  <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
            zero_ff <= (dx_ff == 33'sd0) && (dy_ff == 33'sd0);
         end
         ST_ROOT: begin
            if (zero_ff) begin
               step_x_ff  <= '0;
               step_y_ff  <= '0;
               count_ff   <= CW'(1);
               heading_ff <= req_ff.pose_heading;
            end
            if (sq_done) d_ff <= sq_root;
            if (cr_done) heading_ff <= cr_angle;
         end
         ST_MULL: begin
            // short segment: one point at the target
            step_x_ff <= dx_ff;
            step_y_ff <= dy_ff;
            count_ff  <= CW'(1);
            prodx_ff  <= 63'(l_eff) * 63'(ax_ff);
            prody_ff  <= 63'(l_eff) * 63'(ay_ff);
         end
         ST_DIVX: begin
            if (div_done) step_x_ff <= dx_ff[32] ? 33'(-qstep) : 33'(qstep);
         end
         ST_DIVY: begin
            if (div_done) step_y_ff <= dy_ff[32] ? 33'(-qstep) : 33'(qstep);
         end
         ST_DIVC: begin
            if (div_done) begin
               count_ff <= (cnt33 > MAX_CNT33) ? CW'(slgt_pkg::MAX_PATH_POINTS)
                                               : cnt33[CW-1:0];
            end
         end
         ST_WMUL: begin
            nprod_x_ff <= $signed({1'b0, n_w}) * step_x_ff;
            nprod_y_ff <= $signed({1'b0, n_w}) * step_y_ff;
            la_sq_ff   <= 62'(lookahead_ff) * 62'(lookahead_ff);
         end
         ST_WADD: begin
            acc_x_ff <= 45'(origin_x_ff) + nprod_x_ff;
            acc_y_ff <= 45'(origin_y_ff) + nprod_y_ff;
         end
         ST_WPT: begin
            gx_ff <= sat32(acc_x_ff);
            gy_ff <= sat32(acc_y_ff);
         end
         ST_WDIF: begin
            far_ff <= mx_w[32] | mx_w[31] | my_w[32] | my_w[31];
            ax_ff  <= {1'b0, mx_w[30:0]};
            ay_ff  <= {1'b0, my_w[30:0]};
         end
         ST_WSQ: begin
            sqx_ff <= ax_ff * ax_ff;
            sqy_ff <= ay_ff * ay_ff;
         end
         ST_WCMP: begin
            // step to the next point while this one is too close
            if (more && close) begin
               idx_ff   <= n_w[IW-1:0];
               acc_x_ff <= acc_x_ff + 45'(step_x_ff);
               acc_y_ff <= acc_y_ff + 45'(step_y_ff);
            end
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         rsp_ff.goal_x        <= gx_ff;
         rsp_ff.goal_y        <= gy_ff;
         rsp_ff.goal_heading  <= heading_ff;
         rsp_ff.goal_position <= idx_ff;
         rsp_ff.end_of_path   <= (n_w == count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   slgt_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand ({1'b0, sum_ff}),
      .done     (sq_done),
      .root     (sq_root)
   );

   slgt_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .dx    (dx_ff),
      .dy    (dy_ff),
      .done  (cr_done),
      .angle (cr_angle)
   );

   slgt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

`ifndef NO_ASSERTIONS
   // the walk never looks past the last point
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WCMP) |-> ({1'b0, idx_ff} < count_ff))
      else $error("walk index beyond point count");

   // an accepted item always reads its context next
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_READ))
      else $error("accepted item did not read context");

   // the divider never starts on a zero divisor
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> (div_den != 33'd0))
      else $error("divider started with zero divisor");

   // a loaded result is valid on the output and the block is back in idle
   assert property (@(posedge clock) disable iff (reset)
      out_take |=> rsp_valid && (state_ff == ST_IDLE))
      else $error("result load lost");
`endif

endmodule

/* rtl/slgt_sqrt.sv */
// ----------------------------------------------------------------------------
// slgt_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module slgt_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [65:0] radicand,
   output logic        done,
   output logic [32:0] root
);

   logic [65:0] rad_ff;
   logic [35:0] rem_ff;
   logic [32:0] root_ff;
   logic [5:0]  cnt_ff;
   logic        run_ff;
   logic        done_ff;

   logic [35:0] rem_sh;
   logic [35:0] trial;
   logic        fits;

   // bring down two radicand bits, try the next root bit
   assign rem_sh = {rem_ff[33:0], rad_ff[65:64]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign fits   = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= 6'd32;
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            rad_ff  <= {rad_ff[63:0], 2'b00};
            rem_ff  <= fits ? rem_sh - trial : rem_sh;
            root_ff <= {root_ff[31:0], fits};
            if (cnt_ff == 6'd0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* rtl/slgt_cordic.sv */
// ----------------------------------------------------------------------------
// slgt_cordic
// Vectoring CORDIC for the segment heading: normalize one doubling per cycle,
// then 32 rotation steps, one per cycle.
// ----------------------------------------------------------------------------
module slgt_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] dx,
   input  logic signed [32:0] dy,
   output logic               done,
   output logic        [15:0] angle
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_NORM = 2'd1;
   localparam logic [1:0] PH_ROT  = 2'd2;

   localparam logic [31:0] ROUND_HALF = 32'd1 << (31 - slgt_pkg::ANGLE_BITS);

   logic [1:0]         phase_ff;
   logic signed [45:0] x_ff;
   logic signed [45:0] y_ff;
   logic [31:0]        ang_ff;
   logic [4:0]         it_ff;
   logic               done_ff;

   logic signed [45:0] xs;
   logic signed [45:0] ys;
   logic [45:0]        y_mag;
   logic               big;
   logic [31:0]        ang_rnd;

   assign xs    = x_ff >>> it_ff;
   assign ys    = y_ff >>> it_ff;
   assign y_mag = y_ff[45] ? 46'(-y_ff) : 46'(y_ff);
   assign big   = (|x_ff[45:40]) | (|y_mag[45:40]);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            PH_IDLE: begin
               // fold the left half plane onto the right
               if (start) begin
                  if (dx[32]) begin
                     x_ff   <= -46'(dx);
                     y_ff   <= -46'(dy);
                     ang_ff <= 32'h80000000;
                  end else begin
                     x_ff   <= 46'(dx);
                     y_ff   <= 46'(dy);
                     ang_ff <= '0;
                  end
                  phase_ff <= PH_NORM;
               end
            end
            PH_NORM: begin
               // double until the larger magnitude reaches 2^40
               if (big) begin
                  it_ff    <= '0;
                  phase_ff <= PH_ROT;
               end else begin
                  x_ff <= x_ff <<< 1;
                  y_ff <= y_ff <<< 1;
               end
            end
            PH_ROT: begin
               // rotate toward the x axis
               if (y_ff > 46'sd0) begin
                  x_ff   <= x_ff + ys;
                  y_ff   <= y_ff - xs;
                  ang_ff <= ang_ff + slgt_pkg::atan_tab(it_ff);
               end else begin
                  x_ff   <= x_ff - ys;
                  y_ff   <= y_ff + xs;
                  ang_ff <= ang_ff - slgt_pkg::atan_tab(it_ff);
               end
               if (it_ff == 5'd31) begin
                  phase_ff <= PH_IDLE;
                  done_ff  <= 1'b1;
               end else begin
                  it_ff <= it_ff + 5'd1;
               end
            end
            default: phase_ff <= PH_IDLE;
         endcase
      end
   end

   // round to the output angle resolution
   assign ang_rnd = ang_ff + ROUND_HALF;
   assign angle   = ang_rnd[31 -: slgt_pkg::ANGLE_BITS];
   assign done    = done_ff;

endmodule

/* rtl/slgt_div.sv */
// ----------------------------------------------------------------------------
// slgt_div
// Restoring divider, 33 quotient bits, one bit per cycle. The caller keeps
// the quotient below 2^33 so the upper numerator half is below the divisor.
// ----------------------------------------------------------------------------
module slgt_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [65:0] num,
   input  logic [32:0] den,
   output logic        done,
   output logic [32:0] quo
);

   logic [32:0] rem_ff;
   logic [32:0] low_ff;
   logic [32:0] den_ff;
   logic [32:0] quo_ff;
   logic [5:0]  cnt_ff;
   logic        run_ff;
   logic        done_ff;

   logic [33:0] rem_sh;
   logic        ge;
   logic [33:0] rem_sub;

   assign rem_sh  = {rem_ff, low_ff[32]};
   assign ge      = (rem_sh >= {1'b0, den_ff});
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= num[65:33];
            low_ff <= num[32:0];
            den_ff <= den;
            quo_ff <= '0;
            cnt_ff <= 6'd32;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            // shift in one numerator bit, subtract when it fits
            rem_ff <= ge ? rem_sub[32:0] : rem_sh[32:0];
            low_ff <= {low_ff[31:0], 1'b0};
            quo_ff <= {quo_ff[31:0], ge};
            if (cnt_ff == 6'd0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

/* tb/sv/slgt_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slgt_checker
// Watches the request, result and register ports of the goal tracker. It
// predicts the goal that each accepted item should produce, queues it and
// compares every accepted result with the oldest queued goal, field by field.
// ----------------------------------------------------------------------------
module slgt_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  slgt_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  slgt_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [30:0]       csr_wdata,
   output int                errors,
   output int                goals_waiting
);

   // shadow registers and path record
   logic [30:0] spacing;
   logic [30:0] reach;
   longint      base_x, base_y, delta_x, delta_y;
   logic [15:0] path_yaw;
   int          num_points;
   int          goal_idx;

   slgt_pkg::rsp_type goal_queue[$];

   assign goals_waiting = goal_queue.size();

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned absval(input longint v);
      return (v < 0) ? longint'(0) - v : v;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // vectoring CORDIC, 2^32 units per turn, rounded to ANGLE_BITS
   function automatic logic [15:0] heading_of(input longint x, input longint y);
      logic [31:0]     ang;
      longint unsigned m;
      longint          xs, ys;
      ang = 32'd0;
      if (x < 0) begin
         x = -x;
         y = -y;
         ang = 32'h80000000;
      end
      m = (absval(x) > absval(y)) ? absval(x) : absval(y);
      while (m < (64'd1 << 40)) begin
         x = x * 2;
         y = y * 2;
         m = m << 1;
      end
      for (int i = 0; i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            ang = ang + slgt_pkg::atan_tab(5'(i));
         end else begin
            x = x - ys;
            y = y + xs;
            ang = ang - slgt_pkg::atan_tab(5'(i));
         end
      end
      ang = ang + (32'd1 << (31 - slgt_pkg::ANGLE_BITS));
      return ang[31:32-slgt_pkg::ANGLE_BITS];
   endfunction

   function automatic void point_xy(input int k, output longint gx, output longint gy);
      longint n;
      n = k + 1;
      gx = clamp32(base_x + n * delta_x);
      gy = clamp32(base_y + n * delta_y);
   endfunction

   function automatic bit inside_reach(input longint gx, input longint gy,
                                       input longint px, input longint py);
      longint unsigned ax, ay, la;
      ax = absval(gx - px);
      ay = absval(gy - py);
      la = reach;
      if (ax >= 64'h80000000 || ay >= 64'h80000000) return 1'b0;
      return (ax * ax + ay * ay) < (la * la);
   endfunction

   // lay out a new path from a segment
   function automatic void lay_path(input longint sx, input longint sy,
                                    input longint tx, input longint ty,
                                    input logic [15:0] yaw);
      longint          dx, dy;
      longint unsigned ax, ay, sqx, lo, sq, r, t, d, len, qx, qy, q;
      dx = tx - sx;
      dy = ty - sy;
      ax = absval(dx);
      ay = absval(dy);
      sqx = ax * ax;
      lo = sqx + ay * ay;
      sq = ((lo < sqx) ? (64'd1 << 62) : 64'd0) | (lo >> 2);
      len = (spacing != 0) ? spacing : 1;
      base_x = sx;
      base_y = sy;
      goal_idx = 0;
      r = root_floor(sq);
      t = r * r + r;
      d = 2 * r + ((t < sq || (t == sq && lo[1:0] != 2'd0)) ? 1 : 0);
      if (dx == 0 && dy == 0) begin
         delta_x = 0;
         delta_y = 0;
         num_points = 1;
         path_yaw = yaw;
         return;
      end
      path_yaw = heading_of(dx, dy);
      if (d < len) begin
         delta_x = dx;
         delta_y = dy;
         num_points = 1;
         return;
      end
      qx = (len * ax + d / 2) / d;
      qy = (len * ay + d / 2) / d;
      q = (d + len - 1) / len;
      delta_x = (dx < 0) ? -longint'(qx) : longint'(qx);
      delta_y = (dy < 0) ? -longint'(qy) : longint'(qy);
      q = (q > 1) ? q - 1 : 1;
      if (q > slgt_pkg::MAX_PATH_POINTS) q = slgt_pkg::MAX_PATH_POINTS;
      num_points = int'(q);
   endfunction

   // advance the goal index from a reference position and build the result
   function automatic slgt_pkg::rsp_type pick_goal(input slgt_pkg::req_type r);
      longint            px, py, gx, gy;
      slgt_pkg::rsp_type g;
      px = longint'(r.pos_x);
      py = longint'(r.pos_y);
      if (r.op == slgt_pkg::OP_LOAD)
         lay_path(px, py, longint'(r.target_x), longint'(r.target_y),
                  r.pose_heading);
      if (goal_idx >= num_points) goal_idx = num_points - 1;
      point_xy(goal_idx, gx, gy);
      while (goal_idx + 1 < num_points && inside_reach(gx, gy, px, py)) begin
         goal_idx++;
         point_xy(goal_idx, gx, gy);
      end
      g.goal_x        = gx[31:0];
      g.goal_y        = gy[31:0];
      g.goal_heading  = path_yaw;
      g.goal_position = goal_idx[slgt_pkg::IDX_W-1:0];
      g.end_of_path   = (goal_idx + 1 == num_points);
      return g;
   endfunction

   always @(posedge clock) begin
      slgt_pkg::rsp_type g;
      if (reset) begin
         spacing    = slgt_pkg::STEP_INTERVAL_RST;
         reach      = slgt_pkg::LOOKAHEAD_RST;
         base_x     = 0;
         base_y     = 0;
         delta_x    = 0;
         delta_y    = 0;
         path_yaw   = 0;
         num_points = 1;
         goal_idx   = 0;
         errors    <= 0;
         goal_queue.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == slgt_pkg::CSR_STEP_INTERVAL) spacing = csr_wdata;
            else reach = csr_wdata;
         end
         // append the predicted goal at the tail
         if (req_valid && req_ready)
            goal_queue = {goal_queue, pick_goal(req_data)};
         if (rsp_valid && rsp_ready) begin
            if (goal_queue.size() == 0) begin
               $error("result with no item pending: %p", rsp_data);
               errors <= errors + 1;
            end else begin
               int bad;
               g = goal_queue.pop_front();
               bad = 0;
               if (rsp_data.goal_x !== g.goal_x) begin
                  $error("goal_x expected %0d actual %0d", g.goal_x, rsp_data.goal_x);
                  bad++;
               end
               if (rsp_data.goal_y !== g.goal_y) begin
                  $error("goal_y expected %0d actual %0d", g.goal_y, rsp_data.goal_y);
                  bad++;
               end
               if (rsp_data.goal_heading !== g.goal_heading) begin
                  $error("goal_heading expected %0h actual %0h",
                         g.goal_heading, rsp_data.goal_heading);
                  bad++;
               end
               if (rsp_data.goal_position !== g.goal_position) begin
                  $error("goal_position expected %0d actual %0d",
                         g.goal_position, rsp_data.goal_position);
                  bad++;
               end
               if (rsp_data.end_of_path !== g.end_of_path) begin
                  $error("end_of_path expected %0b actual %0b",
                         g.end_of_path, rsp_data.end_of_path);
                  bad++;
               end
               errors <= errors + bad;
            end
         end
      end
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives segment and pose items into the goal tracker under several register
// settings, with random gaps and result stalls, and reports the verdict that
// the checker's error count gives.
// ----------------------------------------------------------------------------
module tb;

   localparam int     M         = 65536;
   localparam longint CYCLE_CAP = 20000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   slgt_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   slgt_pkg::rsp_type rsp_data;
   logic              csr_we = 1'b0;
   logic              csr_index = slgt_pkg::CSR_STEP_INTERVAL;
   logic [30:0]       csr_wdata = '0;

   int     errors;
   int     goals_waiting;
   int     items_sent = 0;
   bit     calm = 1'b0;
   longint cycles = 0;
   int     hold_left = 0;
   bit     held = 1'b0;

   // last segment, used to place poses along it
   longint seg_sx = 0, seg_sy = 0, seg_tx = 0, seg_ty = 0;

   segment_lookahead_goal_tracker dut (.*);

   slgt_checker check (.*);

   always #5 clock = ~clock;

   // cycle budget
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (!held && items_sent >= 250) begin
         held = 1'b1;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 9);
      end
   end

   task automatic send(input slgt_pkg::req_type r);
      if (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (goals_waiting != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_regs(input logic [30:0] spacing, input logic [30:0] reach);
      csr_we    <= 1'b1;
      csr_index <= slgt_pkg::CSR_STEP_INTERVAL;
      csr_wdata <= spacing;
      @(posedge clock);
      csr_index <= slgt_pkg::CSR_LOOKAHEAD;
      csr_wdata <= reach;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   function automatic slgt_pkg::req_type item(input logic op, input longint px,
                                              input longint py, input longint tx,
                                              input longint ty,
                                              input logic [15:0] yaw);
      slgt_pkg::req_type r;
      r.op           = op;
      r.pos_x        = px[31:0];
      r.pos_y        = py[31:0];
      r.target_x     = tx[31:0];
      r.target_y     = ty[31:0];
      r.pose_heading = yaw;
      return r;
   endfunction

   function automatic longint near_coord(input int span_m);
      return longint'($urandom_range(0, 2 * span_m * M)) - longint'(span_m) * M;
   endfunction

   // mostly poses along the last segment, some new segments, some raw noise
   task automatic random_items(input int n, input int span_m);
      slgt_pkg::req_type r;
      logic [191:0]      noise;
      int                pick;
      longint            k;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            r = noise[$bits(slgt_pkg::req_type)-1:0];
            if (r.op == slgt_pkg::OP_LOAD) begin
               seg_sx = r.pos_x;
               seg_sy = r.pos_y;
               seg_tx = r.target_x;
               seg_ty = r.target_y;
            end
         end else if (pick < 30) begin
            seg_sx = near_coord(span_m);
            seg_sy = near_coord(span_m);
            seg_tx = ($urandom_range(9) == 0) ? seg_sx : near_coord(span_m);
            seg_ty = ($urandom_range(9) == 0) ? seg_sy : near_coord(span_m);
            r = item(slgt_pkg::OP_LOAD, seg_sx, seg_sy, seg_tx, seg_ty, 16'($urandom));
         end else begin
            k = $urandom_range(0, 10);
            r = item(slgt_pkg::OP_POSE,
                     seg_sx + (seg_tx - seg_sx) * k / 8 + near_coord(1),
                     seg_sy + (seg_ty - seg_sy) * k / 8 + near_coord(1),
                     longint'($urandom), longint'($urandom), 16'($urandom));
         end
         send(r);
      end
   endtask

   initial begin
      longint hi, lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, 1 m spacing and 5 m look-ahead
      send(item(slgt_pkg::OP_POSE, 0, 0, 0, 0, 16'h0000));   // pose before any segment
      send(item(slgt_pkg::OP_LOAD, 3 * M, 4 * M, 3 * M, 4 * M, 16'hFFFF)); // zero length
      send(item(slgt_pkg::OP_POSE, 3 * M, 4 * M, 0, 0, 16'h0000));
      send(item(slgt_pkg::OP_LOAD, 0, 0, M / 2, 0, 16'h0000)); // shorter than spacing
      send(item(slgt_pkg::OP_LOAD, 0, 0, 10 * M, 0, 16'h1234)); // regular path
      send(item(slgt_pkg::OP_POSE, 7 * M, 0, 0, 0, 16'h0000));
      send(item(slgt_pkg::OP_POSE, 100 * M, 0, 0, 0, 16'h0000));
      send(item(slgt_pkg::OP_POSE, 9 * M, 0, 0, 0, 16'h0000));
      send(item(slgt_pkg::OP_POSE, 20 * M, 0, 0, 0, 16'h0000));
      send(item(slgt_pkg::OP_LOAD, lo, lo, hi, hi, 16'h8000)); // full range, count saturates
      send(item(slgt_pkg::OP_POSE, hi, lo, hi, lo, 16'hFFFF));
      send(item(slgt_pkg::OP_LOAD, hi, 0, lo, 0, 16'h0000));   // negative x direction
      send(item(slgt_pkg::OP_POSE, lo, hi, 0, 0, 16'h0000));
      send(item(slgt_pkg::OP_LOAD, 0, 0, 0, -10 * M, 16'h0000)); // negative y direction
      send(item(slgt_pkg::OP_LOAD, 0, 0, -3 * M, -4 * M, 16'h0000)); // diagonal
      send(item(slgt_pkg::OP_POSE, -2 * M, -3 * M, 0, 0, 16'h0000));
      send(item(slgt_pkg::OP_LOAD, hi - 3 * M, hi - 3 * M, hi, hi, 16'h0000)); // near edge
      send(item(slgt_pkg::OP_POSE, hi, hi, 0, 0, 16'h0000));
      drain();

      // smallest spacing, no look-ahead: long paths, index never moves
      set_regs(31'd1, 31'd0);
      random_items(80, 20);
      drain();

      // zero spacing acts as the smallest one
      set_regs(31'd0, 31'(M));
      random_items(30, 1);
      drain();

      // largest spacing and look-ahead: mostly single point paths
      set_regs(31'h7FFFFFFF, 31'h7FFFFFFF);
      random_items(60, 30);
      drain();

      // huge look-ahead on a 1 m grid: walks mostly run to the end, no idling
      calm = 1'b1;
      set_regs(31'(M), 31'h7FFFFFFF);
      random_items(20, 20);
      drain();
      calm = 1'b0;

      // ordinary random settings
      for (int p = 0; p < 4; p++) begin
         set_regs(31'($urandom_range(M / 4, 4 * M)), 31'($urandom_range(0, 10 * M)));
         random_items(100, 20);
         drain();
      end

      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
